FILE: rtl/nwrl_pkg.sv
// Shared types and constants for the NAT wildcard rule lookup block.
// Holds table sizing, item codes, the stored rule layout and the
// controller/datapath command and status groups. No dependencies.
package nwrl_pkg;

	localparam int unsigned RuleDepth = 64;
	localparam int unsigned IdxW      = $clog2(RuleDepth);
	localparam int unsigned CntW      = $clog2(RuleDepth + 1);

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_EXACT = 2'd1,
		KIND_ADDR  = 2'd2,
		KIND_PORT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_FULL     = 3'd1,
		ST_IGNORED  = 3'd2,
		ST_HIT_EXACT = 3'd3,
		ST_HIT_ADDR = 3'd4,
		ST_HIT_PORT = 3'd5,
		ST_NO_MATCH = 3'd6
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] ip;
		logic [15:0] port;
		logic [31:0] out_ip;
		logic [15:0] out_port;
	} rule_entry_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/nwrl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module nwrl_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/nwrl_ctrl.sv
// Controller state machine for the rule lookup block.
// Sequences load, table scan, drain and finish; depends on nwrl_pkg.
module nwrl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  nwrl_pkg::dp_stat_t   stat,
	output nwrl_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			// let the last read's compare settle
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/nwrl_dp.sv
// Datapath for the rule lookup block: item registers, rule memory, scan
// counter, match tracking and the output register.
// Depends on nwrl_pkg and nwrl_ram.
module nwrl_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nwrl_pkg::ctrl_cmd_t  cmd,
	output nwrl_pkg::dp_stat_t   stat,
	input  logic [1:0]           mode,
	input  logic [31:0]          key_ip,
	input  logic [15:0]          key_port,
	input  logic                 ip_wild,
	input  logic                 port_wild,
	input  logic [31:0]          new_ip,
	input  logic [15:0]          new_port,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           status,
	output logic [31:0]          out_ip,
	output logic [15:0]          out_port
);

	nwrl_pkg::mode_t          mode_q;
	nwrl_pkg::kind_t          kind_q;
	logic [31:0]              ip_q;
	logic [15:0]              port_q;
	logic [31:0]              nip_q;
	logic [15:0]              nport_q;

	logic [nwrl_pkg::CntW-1:0] count_q;
	logic [nwrl_pkg::CntW-1:0] idx_q;
	logic [nwrl_pkg::CntW-1:0] limit;
	logic                      rd_valid_s1;

	nwrl_pkg::kind_t          best_kind_q;
	logic [31:0]              best_ip_q;
	logic [15:0]              best_port_q;

	nwrl_pkg::kind_t          in_kind;
	nwrl_pkg::rule_entry_t    rd_entry;
	nwrl_pkg::rule_entry_t    wr_entry;
	logic                     key_hit;
	logic                     take;
	logic                     wr_en;

	logic                     out_valid_q;
	nwrl_pkg::status_t        status_q;
	nwrl_pkg::status_t        status_d;
	logic [31:0]              out_ip_q;
	logic [15:0]              out_port_q;
	logic [31:0]              res_ip;
	logic [15:0]              res_port;

	always_comb begin
		if (ip_wild && port_wild) begin
			in_kind = nwrl_pkg::KIND_EMPTY;
		end else if (ip_wild) begin
			in_kind = nwrl_pkg::KIND_PORT;
		end else if (port_wild) begin
			in_kind = nwrl_pkg::KIND_ADDR;
		end else begin
			in_kind = nwrl_pkg::KIND_EXACT;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= nwrl_pkg::mode_t'(mode);
			kind_q  <= in_kind;
			ip_q    <= key_ip;
			port_q  <= key_port;
			nip_q   <= new_ip;
			nport_q <= new_port;
		end
	end

	// only inserts and lookups walk the filled slots
	assign limit = (mode_q == nwrl_pkg::MODE_INSERT || mode_q == nwrl_pkg::MODE_LOOKUP)
		? count_q : '0;
	assign stat.scan_last = (idx_q == limit);
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign wr_entry.kind     = kind_q;
	assign wr_entry.ip       = ip_q;
	assign wr_entry.port     = port_q;
	assign wr_entry.out_ip   = nip_q;
	assign wr_entry.out_port = nport_q;

	nwrl_ram #(
		.Width ($bits(nwrl_pkg::rule_entry_t)),
		.Depth (nwrl_pkg::RuleDepth)
	) u_rules (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[nwrl_pkg::IdxW-1:0]),
		.wdata (wr_entry),
		.re    (cmd.step),
		.raddr (idx_q[nwrl_pkg::IdxW-1:0]),
		.rdata (rd_entry)
	);

	always_comb begin
		case (rd_entry.kind)
			nwrl_pkg::KIND_EXACT: key_hit = (rd_entry.ip == ip_q) && (rd_entry.port == port_q);
			nwrl_pkg::KIND_ADDR:  key_hit = (rd_entry.ip == ip_q);
			nwrl_pkg::KIND_PORT:  key_hit = (rd_entry.port == port_q);
			default:              key_hit = 1'b0;
		endcase
	end

	// keep the first hit of the best kind; inserts only look at their own kind
	assign take = rd_valid_s1 && key_hit
		&& (mode_q != nwrl_pkg::MODE_INSERT || rd_entry.kind == kind_q)
		&& (best_kind_q == nwrl_pkg::KIND_EMPTY || rd_entry.kind < best_kind_q);

	always_ff @(posedge clk) begin
		if (take) begin
			best_ip_q   <= rd_entry.out_ip;
			best_port_q <= rd_entry.out_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			best_kind_q <= nwrl_pkg::KIND_EMPTY;
		end else begin
			rd_valid_s1 <= cmd.step;
			if (cmd.load) begin
				idx_q       <= '0;
				best_kind_q <= nwrl_pkg::KIND_EMPTY;
			end else begin
				if (cmd.step) begin
					idx_q <= idx_q + 1'b1;
				end
				if (take) begin
					best_kind_q <= rd_entry.kind;
				end
			end
		end
	end

	always_comb begin
		status_d = nwrl_pkg::ST_IGNORED;
		res_ip   = '0;
		res_port = '0;
		wr_en    = 1'b0;
		unique case (mode_q)
			nwrl_pkg::MODE_CLEAR: begin
				status_d = nwrl_pkg::ST_DONE;
			end
			nwrl_pkg::MODE_INSERT: begin
				if (kind_q == nwrl_pkg::KIND_EMPTY || best_kind_q != nwrl_pkg::KIND_EMPTY) begin
					status_d = nwrl_pkg::ST_IGNORED;
				end else if (count_q == nwrl_pkg::CntW'(nwrl_pkg::RuleDepth)) begin
					status_d = nwrl_pkg::ST_FULL;
				end else begin
					status_d = nwrl_pkg::ST_DONE;
					wr_en    = cmd.finish;
				end
			end
			nwrl_pkg::MODE_LOOKUP: begin
				case (best_kind_q)
					nwrl_pkg::KIND_EXACT: status_d = nwrl_pkg::ST_HIT_EXACT;
					nwrl_pkg::KIND_ADDR:  status_d = nwrl_pkg::ST_HIT_ADDR;
					nwrl_pkg::KIND_PORT:  status_d = nwrl_pkg::ST_HIT_PORT;
					default:              status_d = nwrl_pkg::ST_NO_MATCH;
				endcase
				if (best_kind_q != nwrl_pkg::KIND_EMPTY) begin
					res_ip   = best_ip_q;
					res_port = best_port_q;
				end
			end
			nwrl_pkg::MODE_RSVD: begin
				status_d = nwrl_pkg::ST_IGNORED;
			end
			default: begin
				status_d = nwrl_pkg::ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish && mode_q == nwrl_pkg::MODE_CLEAR) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q   <= status_d;
			out_ip_q   <= res_ip;
			out_port_q <= res_port;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_ip    = out_ip_q;
	assign out_port  = out_port_q;

endmodule

FILE: rtl/nat_wildcard_rule_lookup_core.sv
// Top level of the NAT wildcard rule lookup block.
// Joins the controller (nwrl_ctrl) and datapath (nwrl_dp); uses nwrl_pkg.
//
//   channel   handshake               payload
//   input     in_valid / in_stall     mode key_ip key_port ip_wild port_wild new_ip new_port
//   output    out_valid / out_stall   status out_ip out_port
//
// Each transaction reads the rule memory once per filled slot for an insert or
// lookup (no slots for clear and the reserved mode), then lets the last compare
// settle in the drain state and posts the result in the finish state.
// Reset empties the table through its fill count; no clearing pass is needed.
// A waiting result sits in the output register while the next transaction is
// taken; only a stalled output register holds the finish step.
module nat_wildcard_rule_lookup_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] key_ip,
	input  logic [15:0] key_port,
	input  logic        ip_wild,
	input  logic        port_wild,
	input  logic [31:0] new_ip,
	input  logic [15:0] new_port,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] out_ip,
	output logic [15:0] out_port
);

	nwrl_pkg::ctrl_cmd_t cmd;
	nwrl_pkg::dp_stat_t  stat;

	nwrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	nwrl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.mode      (mode),
		.key_ip    (key_ip),
		.key_port  (key_port),
		.ip_wild   (ip_wild),
		.port_wild (port_wild),
		.new_ip    (new_ip),
		.new_port  (new_port),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.out_ip    (out_ip),
		.out_port  (out_port)
	);

endmodule
